@@ sv/jts_pkg.sv @@
package jts_pkg;

	localparam int OFFSET_BITS = 32;
	localparam int LEN_BITS    = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_END  = 1'b1;

	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_COMMA     = 8'h2C;
	localparam logic [7:0] CH_MINUS     = 8'h2D;
	localparam logic [7:0] CH_DOT       = 8'h2E;
	localparam logic [7:0] CH_COLON     = 8'h3A;
	localparam logic [7:0] CH_LBRACKET  = 8'h5B;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACKET  = 8'h5D;
	localparam logic [7:0] CH_LBRACE    = 8'h7B;
	localparam logic [7:0] CH_RBRACE    = 8'h7D;

	typedef enum logic [2:0] {
		M_IDLE = 3'd0,
		M_STR  = 3'd1,
		M_ESC  = 3'd2,
		M_INT  = 3'd3,
		M_DOT  = 3'd4,
		M_FRAC = 3'd5,
		M_WORD = 3'd6
	} scan_mode_t;

	typedef enum logic [3:0] {
		TK_LBRACE    = 4'd0,
		TK_RBRACE    = 4'd1,
		TK_LBRACKET  = 4'd2,
		TK_RBRACKET  = 4'd3,
		TK_COMMA     = 4'd4,
		TK_COLON     = 4'd5,
		TK_STRING    = 4'd6,
		TK_NUMBER    = 4'd7,
		TK_TRUE      = 4'd8,
		TK_FALSE     = 4'd9,
		TK_NULL      = 4'd10,
		TK_BAD_CHAR  = 4'd11,
		TK_UNTERM    = 4'd12,
		TK_BAD_WORD  = 4'd13,
		TK_END       = 4'd14
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t             kind;
		logic [LEN_BITS-1:0]   start;
		logic [LEN_BITS-1:0]   length;
	} token_t;

	// All tokens caused by one input word share one line number.
	typedef struct packed {
		token_t [2:0]          toks;
		logic [1:0]            count;
		logic [LEN_BITS-1:0]   line;
	} bundle_t;

endpackage

@@ sv/json_token_scanner_top.sv @@
// A token reaches the output through a queue entry and then the output register once the word that
// completes it is taken, provided the queue holds nothing older and the output register is free.
// Throughput: one text byte per cycle while the output side keeps up; a word that finishes
// several tokens holds the output while they go out one by one, and a four-entry queue between
// the scanner and the output stage absorbs such bursts.
// Reset (asynchronous, active low) puts the scanner between tokens at offset zero, line one.
module json_token_scanner_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  logic                          cmd,
	input  logic [7:0]                    text_byte,
	output logic                          token_valid,
	input  logic                          token_ready,
	output logic [3:0]                    token_kind,
	output logic [jts_pkg::LEN_BITS-1:0]  token_start,
	output logic [jts_pkg::LEN_BITS-1:0]  token_length,
	output logic [jts_pkg::LEN_BITS-1:0]  token_line,
	output logic                          last_of_run
);

	logic              q_push, q_full, q_pop, q_empty;
	jts_pkg::bundle_t  q_in, q_head;

	jts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.text_byte (text_byte),
		.q_full    (q_full),
		.push      (q_push),
		.push_data (q_in)
	);

	jts_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	jts_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (q_empty),
		.head         (q_head),
		.pop          (q_pop),
		.token_valid  (token_valid),
		.token_ready  (token_ready),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.token_line   (token_line),
		.last_of_run  (last_of_run)
	);

endmodule

@@ sv/jts_front.sv @@
module jts_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  logic               cmd,
	input  logic [7:0]         text_byte,
	input  logic               q_full,
	output logic               push,
	output jts_pkg::bundle_t   push_data
);

	localparam logic [39:0] KW_TEXT [3] = '{{"true", 8'h00}, "false", {"null", 8'h00}};
	localparam logic [2:0]  KW_LEN  [3] = '{3'd4, 3'd5, 3'd4};

	localparam logic [jts_pkg::OFFSET_BITS-1:0] POS_MAX = '1;

	jts_pkg::scan_mode_t                 mode_q, mode_d;
	logic [jts_pkg::OFFSET_BITS-1:0]     pos_q, pos_d;
	logic [jts_pkg::OFFSET_BITS-1:0]     begin_q, begin_d;
	logic [jts_pkg::LEN_BITS-1:0]        line_q, line_d;
	logic [2:0]                          wlen_q, wlen_d;
	logic [2:0]                          cand_q, cand_d;

	logic                                accept;
	logic                                is_digit, is_alpha;
	logic [jts_pkg::OFFSET_BITS-1:0]     dpos;
	logic [jts_pkg::LEN_BITS-1:0]        begin32, pos32, dpos32;
	logic [jts_pkg::LEN_BITS-1:0]        len_run, len_str, len_dot;
	logic [jts_pkg::LEN_BITS-1:0]        line_inc;
	jts_pkg::token_t                     tok_num, tok_dot_bad, tok_word;
	jts_pkg::token_t                     f0, f1, tail;
	logic [1:0]                          nf;
	logic                                tail_v, do_idle;

	function automatic logic [2:0] word_add(input logic [2:0] cand, input logic [2:0] wlen,
			input logic [7:0] c);
		logic [2:0] nc;
		logic [7:0] ch;
		nc = cand;
		for (int k = 0; k < 3; k++) begin
			ch = (wlen < 3'd5) ? KW_TEXT[k][8*(4-int'(wlen)) +: 8] : 8'h00;
			if (wlen >= KW_LEN[k] || ch != c) begin
				nc[k] = 1'b0;
			end
		end
		return nc;
	endfunction

	function automatic logic [2:0] wlen_inc(input logic [2:0] wlen);
		return (wlen == 3'd7) ? wlen : wlen + 3'd1;
	endfunction

	assign accept    = cmd_valid && cmd_ready;
	assign cmd_ready = !q_full;

	assign is_digit = text_byte inside {[8'h30:8'h39]};
	assign is_alpha = text_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]};

	assign dpos    = pos_q - 1'b1;
	assign begin32 = 32'(begin_q);
	assign pos32   = 32'(pos_q);
	assign dpos32  = 32'(dpos);
	assign len_run = 32'(pos_q - begin_q);
	assign len_str = 32'(pos_q - begin_q + 1'b1);
	assign len_dot = (dpos < begin_q) ? '0 : 32'(dpos - begin_q);
	assign line_inc = (line_q == '1) ? line_q : line_q + 1'b1;

	always_comb begin
		tok_num.kind   = jts_pkg::TK_NUMBER;
		tok_num.start  = begin32;
		tok_num.length = len_run;

		// The dot that failed to start a fraction is reported on its own.
		tok_dot_bad.kind   = jts_pkg::TK_BAD_CHAR;
		tok_dot_bad.start  = dpos32;
		tok_dot_bad.length = '0;

		tok_word.kind   = jts_pkg::TK_BAD_WORD;
		tok_word.start  = begin32;
		tok_word.length = '0;
		for (int k = 2; k >= 0; k--) begin
			if (cand_q[k] && wlen_q == KW_LEN[k]) begin
				tok_word.kind   = jts_pkg::tok_kind_t'(4'(jts_pkg::TK_TRUE) + 4'(k));
				tok_word.length = len_run;
			end
		end
	end

	always_comb begin
		mode_d  = mode_q;
		pos_d   = pos_q;
		begin_d = begin_q;
		line_d  = line_q;
		wlen_d  = wlen_q;
		cand_d  = cand_q;
		nf      = 2'd0;
		f0      = tok_num;
		f1      = tok_dot_bad;
		tail_v  = 1'b0;
		tail    = '0;
		do_idle = 1'b0;

		if (cmd == jts_pkg::CMD_END) begin
			case (mode_q)
				jts_pkg::M_STR, jts_pkg::M_ESC: begin
					nf = 2'd1;
					f0.kind   = jts_pkg::TK_UNTERM;
					f0.start  = begin32;
					f0.length = '0;
				end
				jts_pkg::M_INT, jts_pkg::M_FRAC: begin
					nf = 2'd1;
				end
				jts_pkg::M_DOT: begin
					nf = 2'd2;
					f0.length = len_dot;
				end
				jts_pkg::M_WORD: begin
					nf = 2'd1;
					f0 = tok_word;
				end
				default: begin
				end
			endcase
			tail_v      = 1'b1;
			tail.kind   = jts_pkg::TK_END;
			tail.start  = pos32;
			tail.length = '0;
			mode_d  = jts_pkg::M_IDLE;
			pos_d   = '0;
			begin_d = '0;
			line_d  = 32'd1;
			wlen_d  = '0;
			cand_d  = '1;
		end else begin
			if (pos_q != POS_MAX) begin
				pos_d = pos_q + 1'b1;
			end
			case (mode_q)
				jts_pkg::M_STR: begin
					if (text_byte == jts_pkg::CH_QUOTE) begin
						nf = 2'd1;
						f0.kind   = jts_pkg::TK_STRING;
						f0.length = len_str;
						mode_d = jts_pkg::M_IDLE;
					end else if (text_byte == jts_pkg::CH_BACKSLASH) begin
						mode_d = jts_pkg::M_ESC;
					end else if (text_byte == jts_pkg::CH_LF) begin
						line_d = line_inc;
					end
				end
				jts_pkg::M_ESC: begin
					mode_d = jts_pkg::M_STR;
				end
				jts_pkg::M_INT: begin
					if (text_byte == jts_pkg::CH_DOT) begin
						mode_d = jts_pkg::M_DOT;
					end else if (!is_digit) begin
						nf = 2'd1;
						do_idle = 1'b1;
					end
				end
				jts_pkg::M_DOT: begin
					if (is_digit) begin
						mode_d = jts_pkg::M_FRAC;
					end else begin
						nf = 2'd2;
						f0.length = len_dot;
						do_idle = 1'b1;
					end
				end
				jts_pkg::M_FRAC: begin
					if (!is_digit) begin
						nf = 2'd1;
						do_idle = 1'b1;
					end
				end
				jts_pkg::M_WORD: begin
					if (is_digit || is_alpha) begin
						cand_d = word_add(cand_q, wlen_q, text_byte);
						wlen_d = wlen_inc(wlen_q);
					end else begin
						nf = 2'd1;
						f0 = tok_word;
						do_idle = 1'b1;
					end
				end
				default: begin
					do_idle = 1'b1;
				end
			endcase

			// The byte that ended a token is scanned again as the start of a new one.
			if (do_idle) begin
				mode_d      = jts_pkg::M_IDLE;
				begin_d     = pos_q;
				tail.start  = pos32;
				tail.length = 32'd1;
				case (text_byte)
					jts_pkg::CH_SPACE, jts_pkg::CH_CR, jts_pkg::CH_TAB: begin
					end
					jts_pkg::CH_LF: begin
						line_d = line_inc;
					end
					jts_pkg::CH_LBRACE: begin
						tail_v    = 1'b1;
						tail.kind = jts_pkg::TK_LBRACE;
					end
					jts_pkg::CH_RBRACE: begin
						tail_v    = 1'b1;
						tail.kind = jts_pkg::TK_RBRACE;
					end
					jts_pkg::CH_LBRACKET: begin
						tail_v    = 1'b1;
						tail.kind = jts_pkg::TK_LBRACKET;
					end
					jts_pkg::CH_RBRACKET: begin
						tail_v    = 1'b1;
						tail.kind = jts_pkg::TK_RBRACKET;
					end
					jts_pkg::CH_COMMA: begin
						tail_v    = 1'b1;
						tail.kind = jts_pkg::TK_COMMA;
					end
					jts_pkg::CH_COLON: begin
						tail_v    = 1'b1;
						tail.kind = jts_pkg::TK_COLON;
					end
					jts_pkg::CH_QUOTE: begin
						mode_d = jts_pkg::M_STR;
					end
					jts_pkg::CH_MINUS: begin
						mode_d = jts_pkg::M_INT;
					end
					default: begin
						if (is_digit) begin
							mode_d = jts_pkg::M_INT;
						end else if (is_alpha) begin
							mode_d = jts_pkg::M_WORD;
							wlen_d = 3'd1;
							cand_d = word_add(3'b111, 3'd0, text_byte);
						end else begin
							tail_v      = 1'b1;
							tail.kind   = jts_pkg::TK_BAD_CHAR;
							tail.length = '0;
						end
					end
				endcase
			end
		end

		push_data.line    = line_q;
		push_data.count   = nf + 2'(tail_v);
		push_data.toks[0] = (nf != 2'd0) ? f0 : tail;
		push_data.toks[1] = (nf == 2'd2) ? f1 : tail;
		push_data.toks[2] = tail;
	end

	assign push = accept && (push_data.count != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= jts_pkg::M_IDLE;
			pos_q   <= '0;
			begin_q <= '0;
			line_q  <= 32'd1;
			wlen_q  <= '0;
			cand_q  <= '1;
		end else if (accept) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			begin_q <= begin_d;
			line_q  <= line_d;
			wlen_q  <= wlen_d;
			cand_q  <= cand_d;
		end
	end

endmodule

@@ sv/jts_queue.sv @@
module jts_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  jts_pkg::bundle_t   push_data,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output jts_pkg::bundle_t   head
);

	jts_pkg::bundle_t                  store_q [jts_pkg::QUEUE_DEPTH];
	logic [jts_pkg::QPTR_BITS-1:0]     wr_q, rd_q;
	logic [jts_pkg::QPTR_BITS:0]       fill_q;

	assign full  = (fill_q == (jts_pkg::QPTR_BITS+1)'(jts_pkg::QUEUE_DEPTH));
	assign empty = (fill_q == '0);
	assign head  = store_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

@@ sv/jts_back.sv @@
module jts_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          empty,
	input  jts_pkg::bundle_t              head,
	output logic                          pop,
	output logic                          token_valid,
	input  logic                          token_ready,
	output logic [3:0]                    token_kind,
	output logic [jts_pkg::LEN_BITS-1:0]  token_start,
	output logic [jts_pkg::LEN_BITS-1:0]  token_length,
	output logic [jts_pkg::LEN_BITS-1:0]  token_line,
	output logic                          last_of_run
);

	logic                          valid_q;
	logic [1:0]                    idx_q;
	jts_pkg::token_t               tok_q;
	logic [jts_pkg::LEN_BITS-1:0]  line_q;
	logic                          last_q;
	logic                          load, is_last;

	assign load    = !valid_q || token_ready;
	assign is_last = (idx_q == head.count - 2'd1);
	assign pop     = load && !empty && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			tok_q  <= head.toks[idx_q];
			line_q <= head.line;
			last_q <= is_last;
		end
	end

	assign token_valid  = valid_q;
	assign token_kind   = tok_q.kind;
	assign token_start  = tok_q.start;
	assign token_length = tok_q.length;
	assign token_line   = line_q;
	assign last_of_run  = last_q;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import jts_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int RESET_CYCLES = 11;
	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 150;
	localparam int TAIL_CYCLES  = 12;
	localparam int MAX_PER_WORD = 3;
	localparam int IDLE_PERCENT = 37;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		tok_kind_t           kind;
		logic [LEN_BITS-1:0] start;
		logic [LEN_BITS-1:0] length;
		logic [LEN_BITS-1:0] line;
		logic                last;
	} token_rec_t;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                cmd_valid   = 1'b0;
	logic                cmd_ready;
	logic                cmd         = CMD_BYTE;
	logic [7:0]          text_byte   = 8'h00;
	logic                token_valid;
	logic                token_ready = 1'b0;
	logic [3:0]          token_kind;
	logic [LEN_BITS-1:0] token_start;
	logic [LEN_BITS-1:0] token_length;
	logic [LEN_BITS-1:0] token_line;
	logic                last_of_run;

	json_token_scanner_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.text_byte    (text_byte),
		.token_valid  (token_valid),
		.token_ready  (token_ready),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.token_line   (token_line),
		.last_of_run  (last_of_run)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Scanner state as the block should hold it.
	scan_mode_t             sc_mode;
	logic [OFFSET_BITS-1:0] sc_pos;
	logic [OFFSET_BITS-1:0] sc_begin;
	logic [31:0]            sc_line;
	logic [2:0]             sc_wlen;
	logic [2:0]             sc_cand;

	string      keywords [3] = '{"true", "false", "null"};
	tok_kind_t  kw_kinds [3] = '{TK_TRUE, TK_FALSE, TK_NULL};
	token_rec_t word_tokens[$];
	token_rec_t pending_tokens[$];

	int  items_sent     = 0;
	int  mismatch_count = 0;
	int  stall_cycles   = 0;
	int  hold_requests  = 0;
	int  hold_served    = 0;
	int  hold_left      = 0;
	bit  tx_steady      = 1'b0;
	bit  rx_steady      = 1'b0;

	function automatic void scanner_reset();
		sc_mode  = M_IDLE;
		sc_pos   = '0;
		sc_begin = '0;
		sc_line  = 32'd1;
		sc_wlen  = '0;
		sc_cand  = 3'b111;
	endfunction

	function automatic void add_token(tok_kind_t k, logic [OFFSET_BITS-1:0] start,
			logic [OFFSET_BITS-1:0] len);
		token_rec_t t;
		if (word_tokens.size() < MAX_PER_WORD) begin
			t.kind   = k;
			t.start  = LEN_BITS'(start);
			t.length = LEN_BITS'(len);
			t.line   = sc_line;
			t.last   = 1'b0;
			word_tokens.insert(word_tokens.size(), t);
		end
	endfunction

	function automatic void line_bump();
		if (sc_line != '1)
			sc_line++;
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic void word_add(logic [7:0] c);
		int i;
		i = sc_wlen;
		for (int k = 0; k < 3; k++) begin
			if (sc_cand[k] && (i >= keywords[k].len() || keywords[k][i] != c))
				sc_cand[k] = 1'b0;
		end
		if (sc_wlen < 7)
			sc_wlen++;
	endfunction

	function automatic void finish_word();
		for (int k = 0; k < 3; k++) begin
			if (sc_cand[k] && sc_wlen == keywords[k].len()) begin
				add_token(kw_kinds[k], sc_begin, sc_pos - sc_begin);
				return;
			end
		end
		add_token(TK_BAD_WORD, sc_begin, '0);
	endfunction

	// The number stops before the dot, and the dot itself is reported as a bad character.
	function automatic void finish_dot();
		logic [OFFSET_BITS-1:0] dpos;
		dpos = sc_pos - 1;
		add_token(TK_NUMBER, sc_begin, (dpos < sc_begin) ? '0 : dpos - sc_begin);
		add_token(TK_BAD_CHAR, dpos, '0);
	endfunction

	function automatic void idle_byte(logic [7:0] c);
		sc_mode  = M_IDLE;
		sc_begin = sc_pos;
		case (c)
			CH_SPACE, CH_CR, CH_TAB: ;
			CH_LF:       line_bump();
			CH_LBRACE:   add_token(TK_LBRACE, sc_pos, 1);
			CH_RBRACE:   add_token(TK_RBRACE, sc_pos, 1);
			CH_LBRACKET: add_token(TK_LBRACKET, sc_pos, 1);
			CH_RBRACKET: add_token(TK_RBRACKET, sc_pos, 1);
			CH_COMMA:    add_token(TK_COMMA, sc_pos, 1);
			CH_COLON:    add_token(TK_COLON, sc_pos, 1);
			CH_QUOTE:    sc_mode = M_STR;
			CH_MINUS:    sc_mode = M_INT;
			default: begin
				if (is_digit(c)) begin
					sc_mode = M_INT;
				end else if (is_alpha(c)) begin
					sc_mode = M_WORD;
					sc_wlen = '0;
					sc_cand = 3'b111;
					word_add(c);
				end else begin
					add_token(TK_BAD_CHAR, sc_pos, '0);
				end
			end
		endcase
	endfunction

	function automatic void scan_text(logic [7:0] c);
		bit rescan;
		rescan = 1'b1;
		case (sc_mode)
			M_STR: begin
				rescan = 1'b0;
				if (c == CH_QUOTE) begin
					add_token(TK_STRING, sc_begin, sc_pos - sc_begin + 1);
					sc_mode = M_IDLE;
				end else if (c == CH_BACKSLASH) begin
					sc_mode = M_ESC;
				end else if (c == CH_LF) begin
					line_bump();
				end
			end
			M_ESC: begin
				rescan  = 1'b0;
				sc_mode = M_STR;
			end
			M_INT: begin
				if (is_digit(c)) begin
					rescan = 1'b0;
				end else if (c == CH_DOT) begin
					rescan  = 1'b0;
					sc_mode = M_DOT;
				end else begin
					add_token(TK_NUMBER, sc_begin, sc_pos - sc_begin);
				end
			end
			M_DOT: begin
				if (is_digit(c)) begin
					rescan  = 1'b0;
					sc_mode = M_FRAC;
				end else begin
					finish_dot();
				end
			end
			M_FRAC: begin
				if (is_digit(c))
					rescan = 1'b0;
				else
					add_token(TK_NUMBER, sc_begin, sc_pos - sc_begin);
			end
			M_WORD: begin
				if (is_digit(c) || is_alpha(c)) begin
					rescan = 1'b0;
					word_add(c);
				end else begin
					finish_word();
				end
			end
			default: ;
		endcase
		if (rescan)
			idle_byte(c);
	endfunction

	function automatic void predict_tokens(logic c, logic [7:0] b);
		word_tokens.delete();
		if (c == CMD_END) begin
			case (sc_mode)
				M_STR, M_ESC:   add_token(TK_UNTERM, sc_begin, '0);
				M_INT, M_FRAC:  add_token(TK_NUMBER, sc_begin, sc_pos - sc_begin);
				M_DOT:          finish_dot();
				M_WORD:         finish_word();
				default: ;
			endcase
			add_token(TK_END, sc_pos, '0);
			scanner_reset();
		end else begin
			scan_text(b);
			if (sc_pos != '1)
				sc_pos++;
		end
		if (word_tokens.size() > 0)
			word_tokens[word_tokens.size() - 1].last = 1'b1;
		foreach (word_tokens[i])
			pending_tokens.insert(pending_tokens.size(), word_tokens[i]);
	endfunction

	task automatic report_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch: %s", what);
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
	endtask

	always @(posedge clk) begin
		token_rec_t want;
		if (arst_n && token_valid && token_ready) begin
			if (pending_tokens.size() == 0) begin
				report_mismatch($sformatf("token kind %0d start %0d with none expected",
					token_kind, token_start));
			end else begin
				want = pending_tokens.pop_front();
				check_field("token_kind", token_kind, want.kind);
				check_field("token_start", token_start, want.start);
				check_field("token_length", token_length, want.length);
				check_field("token_line", token_line, want.line);
				check_field("last_of_run", last_of_run, want.last);
			end
		end
	end

	// Output side: random stalls, steady stretches, and long hold-offs on request.
	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			token_ready <= 1'b0;
		end else if (rx_steady) begin
			token_ready <= 1'b1;
		end else begin
			token_ready <= ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && cmd_ready) || (token_valid && token_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic send_word(logic c, logic [7:0] b);
		while (!tx_steady && $urandom_range(99) < IDLE_PERCENT) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		text_byte <= b;
		do
			@(posedge clk);
		while (!cmd_ready);
		predict_tokens(c, b);
		items_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_word(CMD_BYTE, s[i]);
	endtask

	function automatic logic [7:0] rand_word_char();
		case ($urandom_range(2))
			0:       return "a" + 8'($urandom_range(25));
			1:       return "A" + 8'($urandom_range(25));
			default: return "0" + 8'($urandom_range(9));
		endcase
	endfunction

	task automatic send_string_fragment();
		send_word(CMD_BYTE, CH_QUOTE);
		repeat ($urandom_range(6)) begin
			case ($urandom_range(9))
				0, 1: begin
					send_word(CMD_BYTE, CH_BACKSLASH);
					send_word(CMD_BYTE, 8'($urandom_range(255)));
				end
				2:       send_word(CMD_BYTE, CH_LF);
				3:       send_word(CMD_BYTE, 8'($urandom_range(255)));
				default: send_word(CMD_BYTE, 8'($urandom_range(32, 126)));
			endcase
		end
		if ($urandom_range(9) != 0)
			send_word(CMD_BYTE, CH_QUOTE);
	endtask

	task automatic send_number_fragment();
		int digits;
		if ($urandom_range(2) == 0)
			send_word(CMD_BYTE, CH_MINUS);
		digits = $urandom_range(3);
		repeat (digits)
			send_word(CMD_BYTE, "0" + 8'($urandom_range(9)));
		if ($urandom_range(4) < 2) begin
			send_word(CMD_BYTE, CH_DOT);
			repeat ($urandom_range(2))
				send_word(CMD_BYTE, "0" + 8'($urandom_range(9)));
		end
	endtask

	task automatic send_word_fragment();
		string w;
		int    spot;
		w = keywords[$urandom_range(2)];
		case ($urandom_range(5))
			0, 1: send_text(w);
			2:    send_text(w.substr(0, w.len() - 2));
			3: begin
				send_text(w);
				send_word(CMD_BYTE, rand_word_char());
			end
			4: begin
				spot = $urandom_range(w.len() - 1);
				for (int i = 0; i < w.len(); i++)
					send_word(CMD_BYTE, (i == spot) ? rand_word_char() : w[i]);
			end
			default: begin
				send_word(CMD_BYTE, "a" + 8'($urandom_range(25)));
				repeat ($urandom_range(8))
					send_word(CMD_BYTE, rand_word_char());
			end
		endcase
	endtask

	// Mostly well-formed JSON pieces, with some raw noise and early end markers.
	task automatic send_fragment();
		logic [7:0] marks [6];
		logic [7:0] blanks [4];
		int         pick;
		marks  = '{CH_LBRACE, CH_RBRACE, CH_LBRACKET, CH_RBRACKET, CH_COMMA, CH_COLON};
		blanks = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
		pick   = $urandom_range(99);
		if (pick < 25)
			send_word(CMD_BYTE, marks[$urandom_range(5)]);
		else if (pick < 40)
			send_string_fragment();
		else if (pick < 55)
			send_number_fragment();
		else if (pick < 70)
			send_word_fragment();
		else if (pick < 85)
			send_word(CMD_BYTE, blanks[$urandom_range(3)]);
		else if (pick < 96)
			send_word(CMD_BYTE, 8'($urandom_range(255)));
		else
			send_word(CMD_END, 8'($urandom_range(255)));
	endtask

	task automatic test_punctuation_numbers();
		// Escaped newline, lone minus, and a dot with no digit in front of a bracket.
		send_text("{\"\\\n\":-,1.]");
		send_word(CMD_END, 8'h00);
	endtask

	task automatic test_fractions_bad_bytes();
		send_text("2.5.");
		send_word(CMD_BYTE, 8'hFF);
		send_word(CMD_BYTE, 8'h80);
		send_text("\f.\n\"");
		send_word(CMD_END, 8'hFF);
	endtask

	task automatic test_words_unterminated();
		send_text("null\rtrue false\vnul");
		send_word(CMD_END, 8'h5A);
	endtask

	task automatic test_random_text(int count);
		int target;
		target = items_sent + count;
		while (items_sent < target)
			send_fragment();
	endtask

	task automatic test_drain_pause();
		cmd_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_tokens.size() != 0);
	endtask

	task automatic test_steady_stream();
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		test_random_text(60);
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// Every comma is a token, so the queue fills while the output is held off.
	task automatic test_output_backpressure();
		hold_requests++;
		tx_steady = 1'b1;
		repeat (30)
			send_word(CMD_BYTE, CH_COMMA);
		tx_steady = 1'b0;
	endtask

	initial begin
		scanner_reset();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_punctuation_numbers();
		test_fractions_bad_bytes();
		test_words_unterminated();
		test_random_text(75);
		test_drain_pause();
		test_steady_stream();
		test_output_backpressure();
		test_random_text(60);
		send_word(CMD_END, 8'h00);

		cmd_valid <= 1'b0;
		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
